### rtl/core/ffea_pkg.sv
`timescale 1ns / 1ps
package ffea_pkg;

  localparam int SLOT_SECTORS = 8;
  localparam int MAX_EXTENTS  = 64;
  localparam int SECTOR_BITS  = 24;

  localparam int FIELD_W = 24;
  localparam int IDX_W   = $clog2(MAX_EXTENTS);
  localparam int CNT_W   = $clog2(MAX_EXTENTS + 1);
  localparam int ENT_W   = 2 * SECTOR_BITS;

  localparam logic [SECTOR_BITS:0] SLOT_EXT = (SECTOR_BITS + 1)'(SLOT_SECTORS);
  localparam logic [CNT_W-1:0]     CNT_MAX  = CNT_W'(MAX_EXTENTS);

  // actions
  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // read address select
  localparam logic [1:0] RA_IDX  = 2'd0;
  localparam logic [1:0] RA_NEXT = 2'd1;
  localparam logic [1:0] RA_PREV = 2'd2;

  // write address select
  localparam logic [1:0] WA_IDX  = 2'd0;
  localparam logic [1:0] WA_PREV = 2'd1;
  localparam logic [1:0] WA_ZERO = 2'd2;

  // write data select
  localparam logic [2:0] WD_INIT  = 3'd0;
  localparam logic [2:0] WD_ALLOC = 3'd1;
  localparam logic [2:0] WD_RDATA = 3'd2;
  localparam logic [2:0] WD_BOTH  = 3'd3;
  localparam logic [2:0] WD_RIGHT = 3'd4;
  localparam logic [2:0] WD_LEFT  = 3'd5;
  localparam logic [2:0] WD_NEW   = 3'd6;

  typedef struct packed {
    logic       ld_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       idx_dec;
    logic       idx_ld_cnt;
    logic       pos_ld;
    logic       rd_en;
    logic [1:0] ra_sel;
    logic       wr_en;
    logic [1:0] wa_sel;
    logic [2:0] wd_sel;
    logic       prev_ld;
    logic       cnt_clr;
    logic       cnt_one;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       stage_ld;
    logic [1:0] stage_status;
    logic       stage_slot;
    logic       out_ld;
  } ffea_ctl_t;

  typedef struct packed {
    logic [1:0] act;
    logic       total_zero;
    logic       idx_lt_cnt;
    logic       nxt_lt_cnt;
    logic       idx_gt_pos;
    logic       fits;
    logic       exact;
    logic       first_le_s;
    logic       right;
    logic       left;
    logic       full;
  } ffea_sts_t;

endpackage

### rtl/core/ffea_ram.sv
`timescale 1ns / 1ps
module ffea_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/ffea_datapath.sv
`timescale 1ns / 1ps
module ffea_datapath
  import ffea_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ffea_ctl_t          ctl,
  output ffea_sts_t          sts,
  input  logic               cfg_wr_en,
  input  logic [FIELD_W-1:0] cfg_wr_data,
  input  logic [1:0]         in_action,
  input  logic [FIELD_W-1:0] in_free_start,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_slot_start
);

  localparam int SB = SECTOR_BITS;

  logic [FIELD_W-1:0] total_r;
  logic [1:0]         act_r;
  logic [SB-1:0]      s_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   pos_r;
  logic [ENT_W-1:0]   prev_r;
  logic [1:0]         stage_status_r;
  logic [SB-1:0]      stage_slot_r;
  logic [1:0]         out_status_r;
  logic [FIELD_W-1:0] out_slot_r;

  logic [ENT_W-1:0]   rd_data, wr_data;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [SB-1:0]      cur_first, cur_len, prev_first, prev_len;
  logic [CNT_W-1:0]   idx_p1, idx_m1;

  assign cur_first  = rd_data[ENT_W-1:SB];
  assign cur_len    = rd_data[SB-1:0];
  assign prev_first = prev_r[ENT_W-1:SB];
  assign prev_len   = prev_r[SB-1:0];
  assign idx_p1     = idx_r + CNT_W'(1);
  assign idx_m1     = idx_r - CNT_W'(1);

  always_comb begin
    sts.act        = act_r;
    sts.total_zero = (total_r == '0);
    sts.idx_lt_cnt = (idx_r < cnt_r);
    sts.nxt_lt_cnt = (idx_p1 < cnt_r);
    sts.idx_gt_pos = (idx_r > pos_r);
    sts.fits       = ({1'b0, cur_len} >= SLOT_EXT);
    sts.exact      = ({1'b0, cur_len} == SLOT_EXT);
    sts.first_le_s = (cur_first <= s_r);
    // adjacency sums compared one bit wider, no wrap
    sts.right      = sts.idx_lt_cnt && (({1'b0, s_r} + SLOT_EXT) == {1'b0, cur_first});
    sts.left       = (idx_r != '0) &&
                     ({1'b0, s_r} == ({1'b0, prev_first} + {1'b0, prev_len}));
    sts.full       = (cnt_r >= CNT_MAX);
  end

  always_comb begin
    case (ctl.ra_sel)
      RA_NEXT: rd_addr = idx_p1[IDX_W-1:0];
      RA_PREV: rd_addr = idx_m1[IDX_W-1:0];
      default: rd_addr = idx_r[IDX_W-1:0];
    endcase
    case (ctl.wa_sel)
      WA_PREV: wr_addr = idx_m1[IDX_W-1:0];
      WA_ZERO: wr_addr = '0;
      default: wr_addr = idx_r[IDX_W-1:0];
    endcase
    case (ctl.wd_sel)
      WD_INIT:  wr_data = {{SB{1'b0}}, SB'(total_r)};
      WD_ALLOC: wr_data = {SB'({1'b0, cur_first} + SLOT_EXT),
                           SB'({1'b0, cur_len} - SLOT_EXT)};
      WD_RDATA: wr_data = rd_data;
      WD_BOTH:  wr_data = {prev_first,
                           SB'({1'b0, prev_len} + SLOT_EXT + {1'b0, cur_len})};
      WD_RIGHT: wr_data = {s_r, SB'(SLOT_EXT + {1'b0, cur_len})};
      WD_LEFT:  wr_data = {prev_first, SB'({1'b0, prev_len} + SLOT_EXT)};
      WD_NEW:   wr_data = {s_r, SB'(SLOT_EXT)};
      default:  wr_data = rd_data;
    endcase
  end

  ffea_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_EXTENTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ctl.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (ctl.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.cnt_clr) begin
      cnt_nxt = '0;
    end else if (ctl.cnt_one) begin
      cnt_nxt = CNT_W'(1);
    end else if (ctl.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (ctl.idx_clr) begin
      idx_nxt = '0;
    end else if (ctl.idx_ld_cnt) begin
      idx_nxt = cnt_r;
    end else if (ctl.idx_inc) begin
      idx_nxt = idx_p1;
    end else if (ctl.idx_dec) begin
      idx_nxt = idx_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= FIELD_W'(4096);
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        total_r <= cfg_wr_data;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.ld_in) begin
      act_r <= in_action;
      s_r   <= SB'(in_free_start);
    end
    if (ctl.pos_ld) begin
      pos_r <= idx_r;
    end
    if (ctl.prev_ld) begin
      prev_r <= rd_data;
    end
    if (ctl.stage_ld) begin
      stage_status_r <= ctl.stage_status;
      stage_slot_r   <= ctl.stage_slot ? cur_first : '0;
    end
    if (ctl.out_ld) begin
      out_status_r <= stage_status_r;
      out_slot_r   <= FIELD_W'(stage_slot_r);
    end
  end

  assign out_status     = out_status_r;
  assign out_slot_start = out_slot_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX) else $error("extent count above table size");
  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cnt_inc |-> cnt_r < CNT_MAX) else $error("insert into full table");
  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cnt_dec |-> cnt_r != '0) else $error("drop from empty table");
  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr_en && ctl.wd_sel == WD_RDATA) |-> idx_r < CNT_MAX)
    else $error("shift write beyond table");
`endif

endmodule

### rtl/core/ffea_ctrl.sv
`timescale 1ns / 1ps
module ffea_ctrl
  import ffea_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ffea_sts_t sts,
  output ffea_ctl_t ctl
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_A_RD    = 4'd2;
  localparam logic [3:0] S_A_EV    = 4'd3;
  localparam logic [3:0] S_DROP_RD = 4'd4;
  localparam logic [3:0] S_DROP_WR = 4'd5;
  localparam logic [3:0] S_F_RD    = 4'd6;
  localparam logic [3:0] S_F_EV    = 4'd7;
  localparam logic [3:0] S_F_DEC   = 4'd8;
  localparam logic [3:0] S_I_RD    = 4'd9;
  localparam logic [3:0] S_I_WR    = 4'd10;
  localparam logic [3:0] S_RESP    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.ld_in = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        ctl.idx_clr      = 1'b1;
        ctl.stage_ld     = 1'b1;
        ctl.stage_status = ST_OK;
        case (sts.act)
          ACT_INIT: begin
            if (sts.total_zero) begin
              ctl.cnt_clr = 1'b1;
            end else begin
              ctl.wr_en  = 1'b1;
              ctl.wa_sel = WA_ZERO;
              ctl.wd_sel = WD_INIT;
              ctl.cnt_one = 1'b1;
            end
            state_nxt = S_RESP;
          end
          ACT_ALLOC: state_nxt = S_A_RD;
          ACT_FREE:  state_nxt = S_F_RD;
          default:   state_nxt = S_RESP;
        endcase
      end
      S_A_RD: begin
        if (sts.idx_lt_cnt) begin
          ctl.rd_en = 1'b1;
          state_nxt = S_A_EV;
        end else begin
          ctl.stage_ld     = 1'b1;
          ctl.stage_status = ST_NO_FIT;
          state_nxt        = S_RESP;
        end
      end
      S_A_EV: begin
        if (sts.fits) begin
          ctl.stage_ld     = 1'b1;
          ctl.stage_status = ST_OK;
          ctl.stage_slot   = 1'b1;
          if (sts.exact) begin
            state_nxt = S_DROP_RD;
          end else begin
            ctl.wr_en  = 1'b1;
            ctl.wd_sel = WD_ALLOC;
            state_nxt  = S_RESP;
          end
        end else begin
          ctl.idx_inc = 1'b1;
          state_nxt   = S_A_RD;
        end
      end
      // close the gap at idx by moving later entries down one place
      S_DROP_RD: begin
        if (sts.nxt_lt_cnt) begin
          ctl.rd_en  = 1'b1;
          ctl.ra_sel = RA_NEXT;
          state_nxt  = S_DROP_WR;
        end else begin
          ctl.cnt_dec = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_DROP_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wd_sel  = WD_RDATA;
        ctl.idx_inc = 1'b1;
        state_nxt   = S_DROP_RD;
      end
      S_F_RD: begin
        if (sts.idx_lt_cnt) begin
          ctl.rd_en = 1'b1;
          state_nxt = S_F_EV;
        end else begin
          state_nxt = S_F_DEC;
        end
      end
      S_F_EV: begin
        if (sts.first_le_s) begin
          ctl.prev_ld = 1'b1;
          ctl.idx_inc = 1'b1;
          state_nxt   = S_F_RD;
        end else begin
          state_nxt = S_F_DEC;
        end
      end
      S_F_DEC: begin
        ctl.stage_ld     = 1'b1;
        ctl.stage_status = ST_OK;
        if (!sts.right && !sts.left && sts.full) begin
          ctl.stage_status = ST_FULL;
          state_nxt        = S_RESP;
        end else if (sts.right && sts.left) begin
          ctl.wr_en  = 1'b1;
          ctl.wa_sel = WA_PREV;
          ctl.wd_sel = WD_BOTH;
          state_nxt  = S_DROP_RD;
        end else if (sts.right) begin
          ctl.wr_en  = 1'b1;
          ctl.wd_sel = WD_RIGHT;
          state_nxt  = S_RESP;
        end else if (sts.left) begin
          ctl.wr_en  = 1'b1;
          ctl.wa_sel = WA_PREV;
          ctl.wd_sel = WD_LEFT;
          state_nxt  = S_RESP;
        end else begin
          ctl.pos_ld     = 1'b1;
          ctl.idx_ld_cnt = 1'b1;
          state_nxt      = S_I_RD;
        end
      end
      // open a hole at pos by moving entries up from the top
      S_I_RD: begin
        if (sts.idx_gt_pos) begin
          ctl.rd_en  = 1'b1;
          ctl.ra_sel = RA_PREV;
          state_nxt  = S_I_WR;
        end else begin
          ctl.wr_en   = 1'b1;
          ctl.wd_sel  = WD_NEW;
          ctl.cnt_inc = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_I_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wd_sel  = WD_RDATA;
        ctl.idx_dec = 1'b1;
        state_nxt   = S_I_RD;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          ctl.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_word_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_ld |-> (!out_valid_r || !out_stall))
    else $error("result word overwritten while stalled");
  a_accept_starts_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_DISP)
    else $error("accepted word not dispatched");
  a_result_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_ld |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not raise valid");
`endif

endmodule

### rtl/core/first_fit_extent_allocator_core.sv
`timescale 1ns / 1ps
// First-fit free-extent allocator. Holds up to 64 free extents sorted by start sector in a
// single-port-write, registered-read table. Each word gives one result word. Init writes one
// extent for the whole store, or empties the table when the store size is zero; alloc scans
// entries up to the first extent of at least one slot, then moves later entries down when
// that extent is used up; free scans entries up to its place, then moves entries for an
// insert or a double merge. The table has one read port and one write port.
// A result waiting on out_stall does not block the next input word, but the block holds that
// word's result until the waiting one is taken.
module first_fit_extent_allocator_core
  import ffea_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [FIELD_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [FIELD_W-1:0] in_free_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_slot_start
);

  ffea_ctl_t ctl;
  ffea_sts_t sts;

  ffea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  ffea_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_action     (in_action),
    .in_free_start (in_free_start),
    .out_status    (out_status),
    .out_slot_start(out_slot_start)
  );

endmodule

### test/tb_first_fit_extent_allocator_core.sv
`timescale 1ns / 1ps
module tb_first_fit_extent_allocator_core;
  import ffea_pkg::*;

  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 6000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [FIELD_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_action;
  logic [FIELD_W-1:0] in_free_start;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [FIELD_W-1:0] out_slot_start;

  first_fit_extent_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_free_start(in_free_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot_start(out_slot_start)
  );

  // free extent table as the block should hold it
  logic [SECTOR_BITS-1:0] ext_first [MAX_EXTENTS];
  logic [SECTOR_BITS-1:0] ext_len   [MAX_EXTENTS];
  int                     ext_count;
  logic [FIELD_W-1:0]     store_sectors;

  logic [1:0]             want_status [$];
  logic [FIELD_W-1:0]     want_slot   [$];
  logic [FIELD_W-1:0]     held_slots  [$];
  int                     err_count;
  int                     quiet_cycles;
  bit                     calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void remove_extent(input int idx);
    for (int i = idx; i + 1 < ext_count; i++) begin
      ext_first[i] = ext_first[i+1];
      ext_len[i]   = ext_len[i+1];
    end
    ext_count--;
  endfunction

  function automatic void allocate_or_free(input logic [1:0] act, input logic [FIELD_W-1:0] s,
                                           output logic [1:0] st, output logic [FIELD_W-1:0] slot);
    int pos;
    bit right;
    bit left;
    longint len;
    st   = ST_OK;
    slot = '0;
    pos  = 0;
    len  = SLOT_SECTORS;
    if (act == ACT_INIT) begin
      if (store_sectors == 0) begin
        ext_count = 0;
      end else begin
        ext_first[0] = '0;
        ext_len[0]   = store_sectors;
        ext_count    = 1;
      end
    end else if (act == ACT_ALLOC) begin
      st = ST_NO_FIT;
      for (int i = 0; i < ext_count; i++) begin
        if (ext_len[i] >= SLOT_SECTORS) begin
          slot = ext_first[i];
          st   = ST_OK;
          if (ext_len[i] == SLOT_SECTORS) begin
            remove_extent(i);
          end else begin
            ext_first[i] = ext_first[i] + SLOT_SECTORS;
            ext_len[i]   = ext_len[i] - SLOT_SECTORS;
          end
          break;
        end
      end
    end else if (act == ACT_FREE) begin
      while (pos < ext_count && ext_first[pos] <= s) pos++;
      // adjacency is compared on full-width sums
      right = (pos < ext_count) && (longint'(s) + len == longint'(ext_first[pos]));
      left  = (pos > 0) &&
              (longint'(s) == longint'(ext_first[pos-1]) + longint'(ext_len[pos-1]));
      if (!right && !left && ext_count >= MAX_EXTENTS) begin
        st = ST_FULL;
      end else begin
        if (right) begin
          len = len + ext_len[pos];
          remove_extent(pos);
        end
        if (left) begin
          ext_len[pos-1] = SECTOR_BITS'(longint'(ext_len[pos-1]) + len);
        end else begin
          for (int i = ext_count; i > pos; i--) begin
            ext_first[i] = ext_first[i-1];
            ext_len[i]   = ext_len[i-1];
          end
          ext_first[pos] = s;
          ext_len[pos]   = SECTOR_BITS'(len);
          ext_count++;
        end
      end
    end
  endfunction

  task automatic send_word(input logic [1:0] act, input logic [FIELD_W-1:0] s);
    logic [1:0]         st;
    logic [FIELD_W-1:0] slot;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_free_start <= s;
    do @(posedge clk); while (in_stall);
    allocate_or_free(act, s, st, slot);
    want_status.push_back(st);
    want_slot.push_back(slot);
    if (act == ACT_INIT) held_slots.delete();
    if (act == ACT_ALLOC && st == ST_OK) held_slots.push_back(slot);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (want_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_store_size(input logic [FIELD_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    store_sectors = v;
  endtask

  task automatic free_held_slot();
    int k;
    logic [FIELD_W-1:0] s;
    k = $urandom_range(held_slots.size() - 1);
    s = held_slots[k];
    held_slots.delete(k);
    send_word(ACT_FREE, s);
  endtask

  task automatic test_directed();
    // empty table after reset
    send_word(ACT_ALLOC, 24'd0);
    send_word(ACT_FREE, 24'd40);
    send_word(ACT_FREE, 24'd32);
    send_word(ACT_FREE, 24'd48);
    send_word(ACT_FREE, 24'd40);
    send_word(ACT_NONE, 24'hFFFFFF);
    send_word(ACT_INIT, 24'h555555);
    repeat (3) send_word(ACT_ALLOC, 24'hAAAAAA);
    send_word(ACT_FREE, 24'd8);
    send_word(ACT_FREE, 24'd0);
    send_word(ACT_FREE, 24'd16);
    send_word(ACT_FREE, 24'hFFFFFF);
    send_word(ACT_FREE, 24'hFFFFF8);
    wait_idle();
    write_store_size(24'd0);
    send_word(ACT_INIT, 24'd0);
    send_word(ACT_ALLOC, 24'd0);
    wait_idle();
    write_store_size(24'd7);
    send_word(ACT_INIT, 24'd0);
    send_word(ACT_ALLOC, 24'd0);
    wait_idle();
    write_store_size(24'd8);
    send_word(ACT_INIT, 24'd0);
    send_word(ACT_ALLOC, 24'd0);
    send_word(ACT_ALLOC, 24'd0);
    wait_idle();
    write_store_size(24'hFFFFFF);
    send_word(ACT_INIT, 24'd0);
    send_word(ACT_ALLOC, 24'd0);
    wait_idle();
  endtask

  task automatic test_table_full();
    logic [FIELD_W-1:0] s;
    write_store_size(24'd4096);
    send_word(ACT_INIT, 24'd0);
    repeat (140) send_word(ACT_ALLOC, 24'd0);
    // every other slot back gives isolated extents until the table fills
    for (int i = 0; i < 140; i += 2) send_word(ACT_FREE, 24'(i * SLOT_SECTORS));
    for (int i = 1; i < 140; i += 2) send_word(ACT_FREE, 24'(i * SLOT_SECTORS));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [FIELD_W-1:0] sizes [6];
    int pick;
    sizes = '{24'd4096, 24'd64, 24'($urandom_range(2000)), 24'hFFFFFF, 24'd0,
              24'($urandom_range(800, 100))};
    for (int ph = 0; ph < 6; ph++) begin
      write_store_size(sizes[ph]);
      calm = (ph == 1);
      send_word(ACT_INIT, 24'($urandom));
      repeat (270) begin
        pick = $urandom_range(99);
        if (pick < 45) send_word(ACT_ALLOC, 24'($urandom));
        else if (pick < 80 && held_slots.size() != 0) free_held_slot();
        else if (pick < 88) send_word(ACT_FREE, 24'($urandom));
        else if (pick < 91) send_word(ACT_INIT, 24'($urandom));
        else if (pick < 94) send_word(ACT_NONE, 24'($urandom));
        else send_word(ACT_FREE, 24'($urandom_range(sizes[ph] > 0 ? sizes[ph] + 16 : 64)));
      end
      calm = 1'b0;
      wait_idle();
    end
  endtask

  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (want_status.size() == 0) begin
        $error("result word with nothing expected: status %0d slot %0h",
               out_status, out_slot_start);
        err_count++;
      end else begin
        if (out_status !== want_status[0]) begin
          $error("status: expected %0d, got %0d", want_status[0], out_status);
          err_count++;
        end
        if (out_slot_start !== want_slot[0]) begin
          $error("slot_start: expected %0h, got %0h", want_slot[0], out_slot_start);
          err_count++;
        end
        void'(want_status.pop_front());
        void'(want_slot.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_action     = '0;
    in_free_start = '0;
    out_stall     = 1'b0;
    err_count     = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    ext_count     = 0;
    store_sectors = 24'd4096;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random_traffic();
    wait_idle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ffea_pkg.sv
rtl/core/ffea_ram.sv
rtl/core/ffea_datapath.sv
rtl/core/ffea_ctrl.sv
rtl/core/first_fit_extent_allocator_core.sv
test/tb_first_fit_extent_allocator_core.sv
